// ----- rtl/core/swtsu_pkg.sv -----
// Shared types and constants for the sleep/wake time-slice unit.
`default_nettype none

package swtsu_pkg;

    localparam int NUM_PROCS_DEF = 16;

    localparam logic [15:0] SLICE_RESET = 16'd10;
    localparam logic [9:0]  TPSU_RESET  = 10'd100;

    localparam logic REG_SLICE = 1'b0;
    localparam logic REG_TPSU  = 1'b1;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_SLEEP    = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;

    localparam logic [1:0] EV_WAKE    = 2'd0;
    localparam logic [1:0] EV_PREEMPT = 2'd1;
    localparam logic [1:0] EV_DONE    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHARGE,
        S_SLEEP,
        S_DISP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        adv;
        logic        clr_tok_sleep;
        logic        wr_wake;
        logic        clr_run;
        logic        wr_run;
        logic [31:0] wake_val;
        logic [15:0] run_val;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/swtsu_if.sv -----
// Channel interfaces: input items, result words and configuration writes.
`default_nettype none

interface swtsu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  proc_id;
    logic [15:0] sleep_units;

    modport source (output valid, output op, output proc_id, output sleep_units, input ready);
    modport sink (input valid, input op, input proc_id, input sleep_units, output ready);
endinterface

interface swtsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [3:0] event_proc;
    logic       last;

    modport source (output valid, output event_res, output event_proc, output last, input ready);
    modport sink (input valid, input event_res, input event_proc, input last, output ready);
endinterface

interface swtsu_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/swtsu_cell.sv -----
// Per-process cell: wake time, sleeping flag, run count and scan token stage.
`default_nettype none

module swtsu_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swtsu_pkg::cell_cmd_t  cmd,
    input  logic                  sel,
    input  logic                  token_in,
    input  logic [31:0]           tick_count,
    output logic                  token_out,
    output logic                  hit,
    output logic [15:0]           run_count
);

    logic        token_reg;
    logic        asleep_reg;
    logic [31:0] wake_at_reg;
    logic [15:0] run_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg     <= 1'b0;
            asleep_reg    <= 1'b0;
            wake_at_reg   <= '0;
            run_count_reg <= '0;
        end
        else
        begin
            if (cmd.adv)
            begin
                token_reg <= token_in;
            end
            if (sel && cmd.wr_wake)
            begin
                wake_at_reg <= cmd.wake_val;
                asleep_reg  <= 1'b1;
            end
            else if (token_reg && cmd.clr_tok_sleep)
            begin
                asleep_reg <= 1'b0;
            end
            if (sel && cmd.clr_run)
            begin
                run_count_reg <= '0;
            end
            else if (sel && cmd.wr_run)
            begin
                run_count_reg <= cmd.run_val;
            end
        end
    end

    assign token_out = token_reg;
    assign hit       = token_reg && asleep_reg && (wake_at_reg == tick_count);
    assign run_count = run_count_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sleep_wake_time_slice_unit.sv -----
// Top level of the sleep/wake time-slice unit: sequencer, counters and cell row.
//
// Channels: in_ch takes op/proc_id/sleep_units words, out_ch returns
// event_res/event_proc/last words, cfg takes register writes (index 0 is
// slice_ticks, index 1 is ticks_per_sleep_unit), always ready.
// Every input word produces zero or more wake/preempt words followed by one
// done word with last set.
// One word is processed at a time; in_ch.ready is high only when idle.
// Tick: the scan token walks the cell row one process per cycle while
// out_ch does not stall, followed by the charge and done steps. Sleep and
// dispatch pass through their own step then done; an unused op goes to done.
// Results leave through a single output register; while out_ch stalls the
// scan token holds on the hitting cell, so nothing is lost or repeated.
// Reset clears the tick counter, all wake times, sleep flags and run counts,
// marks no process running and loads the register defaults (10 and 100).
`default_nettype none

module sleep_wake_time_slice_unit #(
    parameter int NUM_PROCS = swtsu_pkg::NUM_PROCS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    swtsu_in_if.sink            in_ch,
    swtsu_out_if.source         out_ch,
    swtsu_cfg_if.sink           cfg
);

    localparam int IDX_W = $clog2(NUM_PROCS);

    swtsu_pkg::state_t    state_reg;
    swtsu_pkg::state_t    state_next;
    swtsu_pkg::cell_cmd_t cmd;

    logic [15:0]      slice_reg;
    logic [9:0]       tpsu_reg;
    logic [31:0]      tick_count_reg;
    logic [25:0]      prod_reg;
    logic             run_valid_reg;
    logic [IDX_W-1:0] run_idx_reg;
    logic [IDX_W-1:0] scan_idx_reg;

    logic             out_valid_reg;
    logic [1:0]       out_res_reg;
    logic [3:0]       out_proc_reg;
    logic             out_last_reg;

    logic [NUM_PROCS:0]   tok;
    logic [NUM_PROCS-1:0] hit_vec;
    logic [NUM_PROCS-1:0] sel_vec;
    logic [15:0]          run_cnt [NUM_PROCS];

    logic        in_acc;
    logic        can_load;
    logic        scan_hit;
    logic        scan_last;
    logic        charging;
    logic [15:0] charge_val;
    logic        preempt;
    logic        stall;
    logic        load;
    logic [1:0]  load_res;
    logic [3:0]  load_proc;
    logic        load_last;
    logic [31:0] pid_w;

    assign in_ch.ready = (state_reg == swtsu_pkg::S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;
    assign can_load    = !out_valid_reg || out_ch.ready;
    assign scan_hit    = |hit_vec;
    assign scan_last   = (32'(scan_idx_reg) == 32'(NUM_PROCS - 1));
    assign charging    = run_valid_reg && (run_idx_reg != '0);
    assign charge_val  = run_cnt[run_idx_reg] + 16'd1;
    assign preempt     = charging && (charge_val == slice_reg);
    assign pid_w       = 32'(in_ch.proc_id);

    // Cell row
    assign tok[0] = in_acc && (in_ch.op == swtsu_pkg::OP_TICK);

    for (genvar i = 0; i < NUM_PROCS; i++)
    begin : g_cell
        assign sel_vec[i] = run_valid_reg && (32'(run_idx_reg) == i);

        swtsu_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .sel        (sel_vec[i]),
            .token_in   (tok[i]),
            .tick_count (tick_count_reg),
            .token_out  (tok[i+1]),
            .hit        (hit_vec[i]),
            .run_count  (run_cnt[i])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swtsu_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_ch.op)
                        swtsu_pkg::OP_TICK:     state_next = swtsu_pkg::S_SCAN;
                        swtsu_pkg::OP_SLEEP:    state_next = swtsu_pkg::S_SLEEP;
                        swtsu_pkg::OP_DISPATCH: state_next = swtsu_pkg::S_DISP;
                        default:                state_next = swtsu_pkg::S_DONE;
                    endcase
                end
            end
            swtsu_pkg::S_SCAN:
            begin
                if (!(scan_hit && !can_load) && scan_last)
                begin
                    state_next = swtsu_pkg::S_CHARGE;
                end
            end
            swtsu_pkg::S_CHARGE:
            begin
                if (!(preempt && !can_load))
                begin
                    state_next = swtsu_pkg::S_DONE;
                end
            end
            swtsu_pkg::S_SLEEP: state_next = swtsu_pkg::S_DONE;
            swtsu_pkg::S_DISP:  state_next = swtsu_pkg::S_DONE;
            swtsu_pkg::S_DONE:
            begin
                if (can_load)
                begin
                    state_next = swtsu_pkg::S_IDLE;
                end
            end
            default: state_next = swtsu_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        cmd           = '0;
        cmd.wake_val  = tick_count_reg + 32'(prod_reg);
        cmd.run_val   = charge_val;
        stall         = 1'b0;
        load          = 1'b0;
        load_res      = swtsu_pkg::EV_DONE;
        load_proc     = 4'd0;
        load_last     = 1'b0;
        case (state_reg)
            swtsu_pkg::S_IDLE:
            begin
                cmd.adv = 1'b1;
            end
            swtsu_pkg::S_SCAN:
            begin
                stall             = scan_hit && !can_load;
                cmd.adv           = !stall;
                cmd.clr_tok_sleep = scan_hit && !stall;
                load              = scan_hit && !stall;
                load_res          = swtsu_pkg::EV_WAKE;
                load_proc         = 4'(32'(scan_idx_reg));
            end
            swtsu_pkg::S_CHARGE:
            begin
                stall      = preempt && !can_load;
                cmd.wr_run = charging && !stall;
                load       = preempt && !stall;
                load_res   = swtsu_pkg::EV_PREEMPT;
                load_proc  = 4'(32'(run_idx_reg));
            end
            swtsu_pkg::S_SLEEP:
            begin
                cmd.wr_wake = 1'b1;
            end
            swtsu_pkg::S_DISP:
            begin
                cmd.clr_run = 1'b1;
            end
            swtsu_pkg::S_DONE:
            begin
                load      = can_load;
                load_res  = swtsu_pkg::EV_DONE;
                load_last = 1'b1;
            end
            default:
            begin
                cmd.adv = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= swtsu_pkg::S_IDLE;
            slice_reg      <= swtsu_pkg::SLICE_RESET;
            tpsu_reg       <= swtsu_pkg::TPSU_RESET;
            tick_count_reg <= '0;
            run_valid_reg  <= 1'b0;
            run_idx_reg    <= '0;
            scan_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                if (cfg.index == swtsu_pkg::REG_SLICE)
                begin
                    slice_reg <= cfg.data;
                end
                else
                begin
                    tpsu_reg <= cfg.data[9:0];
                end
            end

            if (in_acc)
            begin
                scan_idx_reg <= '0;
                case (in_ch.op)
                    swtsu_pkg::OP_TICK:
                    begin
                        tick_count_reg <= tick_count_reg + 32'd1;
                    end
                    swtsu_pkg::OP_DISPATCH:
                    begin
                        run_valid_reg <= (pid_w < 32'(NUM_PROCS));
                        run_idx_reg   <= pid_w[IDX_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (state_reg == swtsu_pkg::S_SCAN && !stall)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end

            if (state_reg == swtsu_pkg::S_SLEEP)
            begin
                run_valid_reg <= 1'b0;
            end
            if (state_reg == swtsu_pkg::S_CHARGE && preempt && !stall)
            begin
                run_valid_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            prod_reg <= 26'(in_ch.sleep_units) * 26'(tpsu_reg);
        end
        if (load)
        begin
            out_res_reg  <= load_res;
            out_proc_reg <= load_proc;
            out_last_reg <= load_last;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.event_res  = out_res_reg;
    assign out_ch.event_proc = out_proc_reg;
    assign out_ch.last       = out_last_reg;

endmodule

`default_nettype wire
